>>> sv/grid_trilinear_sampler_unit_macros.svh
// Assertion macros for the grid trilinear sampler controller
`ifndef GRID_TRILINEAR_SAMPLER_UNIT_MACROS_SVH
`define GRID_TRILINEAR_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, off while reset is high
`define GTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off while reset is high
`define GTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/gts_pkg.sv
// Constants, codes and controller/datapath interface types of the grid sampler
package gts_pkg;

   localparam int CHUNK_SIZE = 16;
   localparam int CELL_X     = 4;
   localparam int CELL_Y     = 4;
   localparam int CELL_Z     = 4;
   localparam int VALUE_BITS = 16;

   localparam int GRID_W     = CHUNK_SIZE / CELL_X + 1;
   localparam int GRID_H     = CHUNK_SIZE / CELL_Y + 1;
   localparam int GRID_D     = CHUNK_SIZE / CELL_Z + 1;
   localparam int GRID_TOTAL = GRID_W * GRID_H * GRID_D;

   localparam int IDX_W  = 7;
   localparam int POS_W  = 4;
   localparam int ADDR_W = $clog2(GRID_TOTAL);

   localparam int SX = $clog2(CELL_X);
   localparam int SY = $clog2(CELL_Y);
   localparam int SZ = $clog2(CELL_Z);
   localparam int SXY    = (SX > SY) ? SX : SY;
   localparam int FRAC_W = (SXY > SZ) ? SXY : SZ;
   localparam int SH_W   = $clog2(FRAC_W + 1);

   localparam int DIFF_W = VALUE_BITS + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   localparam int CORNERS = 8;
   localparam int STEP_W  = $clog2(CORNERS);

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE = 3'd0;
   localparam logic [OP_W-1:0] OP_X0   = 3'd1;
   localparam logic [OP_W-1:0] OP_X1   = 3'd2;
   localparam logic [OP_W-1:0] OP_Y0   = 3'd3;
   localparam logic [OP_W-1:0] OP_Y1   = 3'd4;
   localparam logic [OP_W-1:0] OP_Z    = 3'd5;

   typedef struct packed {
      logic              capture;
      logic              mem_write;
      logic              mem_read;
      logic [STEP_W-1:0] step;
      logic              load_a;
      logic [OP_W-1:0]   op;
      logic              load_out;
   } gts_cmd_type;

   typedef struct packed {
      logic index_ok;
   } gts_status_type;

endpackage

>>> sv/gts_datapath.sv
// Lattice memory, corner addressing and shared lerp unit of the grid sampler
module gts_datapath import gts_pkg::*; (
   input  logic                         clock,
   input  gts_cmd_type                  cmd,
   output gts_status_type               status,
   input  logic [IDX_W-1:0]             req_grid_index,
   input  logic signed [VALUE_BITS-1:0] req_grid_value,
   input  logic [POS_W-1:0]             req_local_x,
   input  logic [POS_W-1:0]             req_local_y,
   input  logic [POS_W-1:0]             req_local_z,
   output logic signed [VALUE_BITS-1:0] rsp_sample_value
);

   logic [VALUE_BITS-1:0] grid_mem [GRID_TOTAL];

   logic [POS_W-1:0]             px_ff, py_ff, pz_ff;
   logic signed [VALUE_BITS-1:0] rdata_ff, a_ff, x0_ff, x1_ff, y0_ff, y1_ff, out_ff;

   logic [ADDR_W-1:0] ax, ay, az, rd_addr, mem_addr;
   logic [FRAC_W-1:0] fx, fy, fz;

   logic signed [VALUE_BITS-1:0] la, lb, lerp_q;
   logic [FRAC_W-1:0]            lf;
   logic [SH_W-1:0]              ls;
   logic signed [DIFF_W-1:0]     diff;
   logic signed [PROD_W-1:0]     prod, part, total;

   assign status.index_ok = (req_grid_index < IDX_W'(GRID_TOTAL));

   assign fx = FRAC_W'(px_ff % CELL_X);
   assign fy = FRAC_W'(py_ff % CELL_Y);
   assign fz = FRAC_W'(pz_ff % CELL_Z);

   always_comb begin
      ax = ADDR_W'(px_ff >> SX) + ADDR_W'(cmd.step[0]);
      ay = ADDR_W'(py_ff >> SY) + ADDR_W'(cmd.step[1]);
      az = ADDR_W'(pz_ff >> SZ) + ADDR_W'(cmd.step[2]);
      rd_addr  = ADDR_W'(GRID_W) * (ADDR_W'(GRID_H) * az + ay) + ax;
      mem_addr = cmd.mem_write ? ADDR_W'(req_grid_index) : rd_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         grid_mem[mem_addr] <= req_grid_value;
      end else if (cmd.mem_read) begin
         rdata_ff <= grid_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= POS_W'(req_local_x % CHUNK_SIZE);
         py_ff <= POS_W'(req_local_y % CHUNK_SIZE);
         pz_ff <= POS_W'(req_local_z % CHUNK_SIZE);
      end
      if (cmd.load_a) begin
         a_ff <= rdata_ff;
      end
   end

   always_comb begin
      unique case (cmd.op) inside
         OP_X0, OP_X1: begin
            la = a_ff;
            lb = rdata_ff;
            lf = fx;
            ls = SH_W'(SX);
         end
         OP_Y0: begin
            la = x0_ff;
            lb = x1_ff;
            lf = fy;
            ls = SH_W'(SY);
         end
         OP_Y1: begin
            la = x0_ff;
            lb = x1_ff;
            lf = fy;
            ls = SH_W'(SY);
         end
         OP_Z: begin
            la = y0_ff;
            lb = y1_ff;
            lf = fz;
            ls = SH_W'(SZ);
         end
         default: begin
            la = a_ff;
            lb = rdata_ff;
            lf = fx;
            ls = SH_W'(SX);
         end
      endcase
   end

   always_comb begin
      diff   = DIFF_W'(lb) - DIFF_W'(la);
      prod   = PROD_W'(diff) * PROD_W'($signed({1'b0, lf}));
      part   = prod >>> ls;
      total  = PROD_W'(la) + part;
      lerp_q = total[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_X0: x0_ff <= lerp_q;
         OP_X1: x1_ff <= lerp_q;
         OP_Y0: y0_ff <= lerp_q;
         OP_Y1: y1_ff <= lerp_q;
         OP_Z: begin
            if (cmd.load_out) begin
               out_ff <= lerp_q;
            end
         end
         default: ;
      endcase
   end

   assign rsp_sample_value = out_ff;

endmodule

>>> sv/gts_controller.sv
// Request sequencer of the grid sampler: handshakes, corner reads, lerp schedule
`include "grid_trilinear_sampler_unit_macros.svh"

module gts_controller import gts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_cmd,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  gts_status_type status,
   output gts_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] CYC_X0A  = 4'd2;
   localparam logic [CNT_W-1:0] CYC_X1A  = 4'd4;
   localparam logic [CNT_W-1:0] CYC_Y0   = 4'd5;
   localparam logic [CNT_W-1:0] CYC_X0B  = 4'd6;
   localparam logic [CNT_W-1:0] CYC_X1B  = 4'd8;
   localparam logic [CNT_W-1:0] CYC_Y1   = 4'd9;
   localparam logic [CNT_W-1:0] CYC_LAST = 4'd10;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.mem_write = status.index_ok;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_RUN;
                  cnt_in      = '0;
               end
            end
         end
         ST_RUN: begin
            cmd.mem_read = (cnt_ff < CNT_W'(CORNERS));
            cmd.step     = cnt_ff[STEP_W-1:0];
            cmd.load_a   = cnt_ff[0] && (cnt_ff < CNT_W'(CORNERS));
            unique case (cnt_ff) inside
               CYC_X0A, CYC_X0B: cmd.op = OP_X0;
               CYC_X1A, CYC_X1B: cmd.op = OP_X1;
               CYC_Y0:           cmd.op = OP_Y0;
               CYC_Y1:           cmd.op = OP_Y1;
               CYC_LAST:         cmd.op = out_free ? OP_Z : OP_NONE;
               default:          cmd.op = OP_NONE;
            endcase
            if (cnt_ff == CYC_LAST) begin
               if (out_free) begin
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `GTS_ASSERT_NOW(a_no_write_in_run, state_ff == ST_RUN, !cmd.mem_write, "memory write during sample")
   `GTS_ASSERT_NOW(a_load_out_free, cmd.load_out, out_free, "result overwritten before taken")
   `GTS_ASSERT_NEXT(a_sample_starts, accept && (req_cmd == CMD_SAMPLE), (state_ff == ST_RUN) && (cnt_ff == '0), "sample did not start")
   `GTS_ASSERT_NEXT(a_run_advances, (state_ff == ST_RUN) && (cnt_ff != CYC_LAST), (state_ff == ST_RUN) && (cnt_ff == $past(cnt_ff) + CNT_W'(1)), "sequence did not advance")

endmodule

>>> sv/grid_trilinear_sampler_unit.sv
// Top level of the grid trilinear sampler: controller and datapath
//
// Request channel (req_valid/req_ready): req_cmd selects a lattice write or a sample.
//   A write stores req_grid_value at req_grid_index (indexes past the lattice are
//   dropped) and gives no response; writes are taken one per cycle while no sample runs.
//   A sample takes req_local_x/y/z and gives one response on rsp_sample_value.
// Response channel (rsp_valid/rsp_ready): one registered result.
// The eight lattice corners come from a single-port memory, one read per cycle, and
//   seven lerps share one multiplier, slotted between and after those reads; the block
//   holds one sample at a time and takes no new request until it has finished the last.
// A stalled receiver does not stop requests: the next sample runs while the result
//   waits, and only the final lerp holds until the output register is free.
// Reset clears the sequencer and the response valid flag; lattice contents are not
//   cleared, and a sample must only touch entries written since reset.
module grid_trilinear_sampler_unit import gts_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [IDX_W-1:0]             req_grid_index,
   input  logic signed [VALUE_BITS-1:0] req_grid_value,
   input  logic [POS_W-1:0]             req_local_x,
   input  logic [POS_W-1:0]             req_local_y,
   input  logic [POS_W-1:0]             req_local_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VALUE_BITS-1:0] rsp_sample_value
);

   gts_cmd_type    cmd;
   gts_status_type status;

   gts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gts_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_grid_index   (req_grid_index),
      .req_grid_value   (req_grid_value),
      .req_local_x      (req_local_x),
      .req_local_y      (req_local_y),
      .req_local_z      (req_local_z),
      .rsp_sample_value (rsp_sample_value)
   );

endmodule

>>> test/grid_trilinear_sampler_unit_checker.sv
// Checker for the grid trilinear sampler: mirrors the lattice, predicts and compares responses
module grid_trilinear_sampler_unit_checker import gts_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [IDX_W-1:0]             req_grid_index,
   input  logic signed [VALUE_BITS-1:0] req_grid_value,
   input  logic [POS_W-1:0]             req_local_x,
   input  logic [POS_W-1:0]             req_local_y,
   input  logic [POS_W-1:0]             req_local_z,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [VALUE_BITS-1:0] rsp_sample_value,
   output int                           error_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [VALUE_BITS-1:0] lattice_copy [GRID_TOTAL];
   logic signed [VALUE_BITS-1:0] blend_due [$];

   function automatic longint lattice_corner(int cx, int cy, int cz);
      int idx;
      idx = cx + GRID_W * (cy + GRID_H * cz);
      if (cx >= GRID_W || cy >= GRID_H || cz >= GRID_D || idx >= GRID_TOTAL) return 0;
      return longint'(lattice_copy[idx]);
   endfunction

   function automatic longint lerp_step(longint a, longint b, int frac, int sh);
      return a + (((b - a) * frac) >>> sh);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] blend_at(int x, int y, int z);
      int px, py, pz, cx, cy, cz, fx, fy, fz;
      longint c00, c10, c01, c11, r0, r1;
      px = x % CHUNK_SIZE;
      py = y % CHUNK_SIZE;
      pz = z % CHUNK_SIZE;
      cx = px / CELL_X;
      fx = px % CELL_X;
      cy = py / CELL_Y;
      fy = py % CELL_Y;
      cz = pz / CELL_Z;
      fz = pz % CELL_Z;
      c00 = lerp_step(lattice_corner(cx, cy, cz), lattice_corner(cx + 1, cy, cz), fx, SX);
      c10 = lerp_step(lattice_corner(cx, cy + 1, cz), lattice_corner(cx + 1, cy + 1, cz),
                      fx, SX);
      c01 = lerp_step(lattice_corner(cx, cy, cz + 1), lattice_corner(cx + 1, cy, cz + 1),
                      fx, SX);
      c11 = lerp_step(lattice_corner(cx, cy + 1, cz + 1),
                      lattice_corner(cx + 1, cy + 1, cz + 1), fx, SX);
      r0 = lerp_step(c00, c10, fy, SY);
      r1 = lerp_step(c01, c11, fy, SY);
      return VALUE_BITS'(lerp_step(r0, r1, fz, SZ));
   endfunction

   always @(posedge clock) begin
      logic signed [VALUE_BITS-1:0] want;
      if (reset) begin
         blend_due.delete();
         foreach (lattice_copy[i]) lattice_copy[i] = '0;
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (blend_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_sample_value);
               error_count <= error_count + 1;
            end else begin
               want = blend_due.pop_front();
               if (rsp_sample_value !== want) begin
                  $display("%0t: sample_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_sample_value);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_SAMPLE) begin
               blend_due.push_back(blend_at(int'(req_local_x), int'(req_local_y),
                                            int'(req_local_z)));
            end else if (int'(req_grid_index) < GRID_TOTAL) begin
               lattice_copy[req_grid_index] = req_grid_value;
            end
         end
         pending_count <= blend_due.size();
      end
   end

endmodule

>>> test/grid_trilinear_sampler_unit_test.sv
// Testbench top for the grid trilinear sampler: request stimulus, response stalls and verdict
module grid_trilinear_sampler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gts_pkg::*;

   localparam int REQUEST_TARGET = 550;
   localparam int QUIET_TAIL     = 60;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int POS_MAX        = (1 << POS_W) - 1;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic                         req_cmd          = CMD_WRITE;
   logic [IDX_W-1:0]             req_grid_index   = '0;
   logic signed [VALUE_BITS-1:0] req_grid_value   = '0;
   logic [POS_W-1:0]             req_local_x      = '0;
   logic [POS_W-1:0]             req_local_y      = '0;
   logic [POS_W-1:0]             req_local_z      = '0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_sample_value;

   int error_count;
   int pending_count;
   int cycle_count    = 0;
   int useful         = 0;
   int writes_done    = 0;
   int writes_dropped = 0;
   int samples_done   = 0;
   bit calm           = 1'b0;
   bit sender_gaps    = 1'b1;
   bit lattice_set [GRID_TOTAL];

   logic signed [VALUE_BITS-1:0] low_cell_values [CORNERS] = '{
      16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff};
   logic signed [VALUE_BITS-1:0] high_cell_values [CORNERS] = '{
      16'sh7fff, 16'sh8000, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh8000};

   grid_trilinear_sampler_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_grid_index   (req_grid_index),
      .req_grid_value   (req_grid_value),
      .req_local_x      (req_local_x),
      .req_local_y      (req_local_y),
      .req_local_z      (req_local_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value)
   );

   grid_trilinear_sampler_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_grid_index   (req_grid_index),
      .req_grid_value   (req_grid_value),
      .req_local_x      (req_local_x),
      .req_local_y      (req_local_y),
      .req_local_z      (req_local_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, pending_count);
      $display("DONE: errors detected");
      $finish;
   end

   // hold the response side back in random bursts until the quiet tail
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if (calm) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if (!calm) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 17)) @(posedge clock);
            end
         end
      end
   end

   function automatic int lattice_index(int x, int y, int z);
      return x + GRID_W * (y + GRID_H * z);
   endfunction

   function automatic int first_unset_corner(int x, int y, int z);
      int cx, cy, cz, idx;
      cx = (x % CHUNK_SIZE) / CELL_X;
      cy = (y % CHUNK_SIZE) / CELL_Y;
      cz = (z % CHUNK_SIZE) / CELL_Z;
      for (int k = 0; k < CORNERS; k++) begin
         idx = lattice_index(cx + (k & 1), cy + ((k >> 1) & 1), cz + (k >> 2));
         if (!lattice_set[idx]) return idx;
      end
      return -1;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_request(input logic cmd, input logic [IDX_W-1:0] idx,
                               input logic signed [VALUE_BITS-1:0] value,
                               input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic [POS_W-1:0] z);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_grid_index <= idx;
      req_grid_value <= value;
      req_local_x    <= x;
      req_local_y    <= y;
      req_local_z    <= z;
      do @(posedge clock); while (!req_ready);
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic issue_write(input logic [IDX_W-1:0] idx,
                              input logic signed [VALUE_BITS-1:0] value);
      push_request(CMD_WRITE, idx, value, POS_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom));
      if (int'(idx) < GRID_TOTAL) begin
         lattice_set[idx] = 1'b1;
         writes_done++;
         useful++;
      end else begin
         writes_dropped++;
      end
   endtask

   task automatic issue_sample(input int x, input int y, input int z);
      push_request(CMD_SAMPLE, IDX_W'($urandom), VALUE_BITS'($urandom), POS_W'(x), POS_W'(y),
                   POS_W'(z));
      samples_done++;
      useful++;
   endtask

   initial begin
      int x, y, z, missing, filled;
      foreach (lattice_set[i]) lattice_set[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < CORNERS; k++) begin
         issue_write(IDX_W'(lattice_index(k & 1, (k >> 1) & 1, k >> 2)), low_cell_values[k]);
      end
      issue_write(IDX_W'(GRID_TOTAL), 16'sh1234);
      issue_write(IDX_W'((1 << IDX_W) - 1), 16'sh8000);
      for (int k = 0; k < CORNERS; k++) begin
         issue_write(IDX_W'(lattice_index(3 + (k & 1), 3 + ((k >> 1) & 1), 3 + (k >> 2))),
                     high_cell_values[k]);
      end
      issue_sample(0, 0, 0);
      issue_sample(3, 3, 3);
      issue_sample(1, 2, 3);
      issue_sample(3, 0, 2);
      issue_sample(12, 12, 12);
      issue_sample(15, 15, 15);
      issue_sample(14, 13, 15);

      // mix in random writes, fill missing corners on demand, then sample once the cell is complete
      while (useful < REQUEST_TARGET) begin
         if (useful % 40 == 0) sender_gaps = 1'($urandom_range(0, 1));
         calm = (useful >= REQUEST_TARGET - QUIET_TAIL);
         if ($urandom_range(0, 99) < 10) begin
            issue_write(IDX_W'($urandom), pick_value());
         end else begin
            x = $urandom_range(0, POS_MAX);
            y = $urandom_range(0, POS_MAX);
            z = $urandom_range(0, POS_MAX);
            missing = first_unset_corner(x, y, z);
            if (missing < 0) begin
               issue_sample(x, y, z);
            end else begin
               issue_write(IDX_W'(missing), pick_value());
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      filled = 0;
      foreach (lattice_set[i]) filled += int'(lattice_set[i]);
      $display("Covered %0d lattice writes, %0d writes past the lattice and %0d samples,",
               writes_done, writes_dropped, samples_done);
      $display("with %0d of %0d lattice entries filled and random stalls on both sides.",
               filled, GRID_TOTAL);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
